>>> sv/position_record_parser_macros.svh
// assertion macros for the position record parser
// no dependencies; included inside module bodies that assert
`ifndef POSITION_RECORD_PARSER_MACROS_SVH
`define POSITION_RECORD_PARSER_MACROS_SVH

// same-cycle implication under the async reset
`define PRP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("position record parser: same-cycle check failed");

// next-cycle implication under the async reset
`define PRP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("position record parser: next-cycle check failed");

`endif

>>> sv/prp_pkg.sv
// shared types, constants and character helpers for the position record parser
// no dependencies
`default_nettype none

package prp_pkg;

    typedef enum logic [1:0] {
        PH_BLANK,
        PH_SIGN,
        PH_DIGITS
    } phase_t;

    localparam logic [7:0] CH_SEP   = 8'h3B; // ';'
    localparam logic [7:0] CH_MINUS = 8'h2D; // '-'
    localparam logic [7:0] CH_N     = 8'h4E;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_W     = 8'h57;

    localparam logic [2:0] TAG_LEN     = 3'd6;
    localparam logic [4:0] FIELD_LIMIT = 5'd24;
    localparam logic [4:0] LAST_FIELD  = 5'd23;

    localparam logic [4:0] FLD_TAG     = 5'd0;
    localparam logic [4:0] FLD_TIME    = 5'd1;
    localparam logic [4:0] FLD_LAT_DEG = 5'd2;
    localparam logic [4:0] FLD_LAT_MIN = 5'd3;
    localparam logic [4:0] FLD_LAT_FRC = 5'd4;
    localparam logic [4:0] FLD_LAT_DIR = 5'd5;
    localparam logic [4:0] FLD_LON_DEG = 5'd6;
    localparam logic [4:0] FLD_LON_MIN = 5'd7;
    localparam logic [4:0] FLD_LON_FRC = 5'd8;
    localparam logic [4:0] FLD_LON_DIR = 5'd9;

    // a digit d overflows when acc*10+d > limit, i.e. acc > q or (acc == q and d > r)
    localparam logic [63:0] POS_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] NEG_LIMIT = 64'h8000_0000_0000_0000;
    localparam logic [63:0] POS_QUOT  = POS_LIMIT / 64'd10;
    localparam logic [63:0] NEG_QUOT  = NEG_LIMIT / 64'd10;
    localparam logic [3:0]  POS_REM   = 4'(POS_LIMIT % 64'd10);
    localparam logic [3:0]  NEG_REM   = 4'(NEG_LIMIT % 64'd10);

    function automatic logic is_blank(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_numeric_field(input logic [4:0] f);
        return (f >= FLD_TIME && f <= FLD_LAT_FRC) ||
               (f >= FLD_LON_DEG && f <= FLD_LON_FRC) ||
               (f >= 5'd10 && f <= 5'd13);
    endfunction

    // expected tag text, one character per match position
    function automatic logic [7:0] tag_char(input logic [2:0] pos);
        logic [7:0] c;
        case (pos)
            3'd0:    c = 8'h67; // g
            3'd1:    c = 8'h70; // p
            3'd2:    c = 8'h73; // s
            3'd3:    c = 8'h72; // r
            3'd4:    c = 8'h6D; // m
            3'd5:    c = 8'h63; // c
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

>>> sv/position_record_parser.sv
// position record parser: byte-wide text in, one decoded record per marked last byte
// depends on prp_pkg and position_record_parser_macros.svh
//
// Input channel: one text byte per beat (char_in, record_end) on byte_valid / byte_stall.
// Output channel: one result beat per record on result_valid / result_stall.
// A beat is taken on a rising edge with valid high and stall low.
// Throughput: one byte per cycle, sustained, while results are being taken.
// A record's last byte is taken into the input register; the parse logic then loads the
// result register from it, once that register is free or its beat is being taken.
// Each byte needs one small update of the field state (a 64-bit multiply-by-ten and
// compare for digits), which is the path between the input and result registers.
// When the receiver stalls, the result register holds its beat; bytes keep flowing
// until a last byte reaches the parse stage with the result register still full.
// Reset (rst_n low, asynchronous) empties both registers and starts a fresh record.
// A record is valid with exactly 24 fields, tag gpsrmc and well-formed number and
// direction fields; an invalid record gives record_valid low and all values zero.
`default_nettype none

module position_record_parser
    import prp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        byte_valid,
    output logic             byte_stall,
    input  wire logic [7:0]  char_in,
    input  wire logic        record_end,

    output logic             result_valid,
    input  wire logic        result_stall,
    output logic             record_valid,
    output logic [31:0]      timestamp,
    output logic [15:0]      lat_degrees,
    output logic [15:0]      lat_minutes,
    output logic [31:0]      lat_fraction,
    output logic             lat_south,
    output logic [15:0]      lon_degrees,
    output logic [15:0]      lon_minutes,
    output logic [31:0]      lon_fraction,
    output logic             lon_west
);

    `include "position_record_parser_macros.svh"

    // input register
    logic       in_valid_reg;
    logic [7:0] in_char_reg;
    logic       in_end_reg;

    // parse state
    logic [4:0]  field_number_reg, field_number_next;
    logic [2:0]  tag_pos_reg, tag_pos_next;
    logic        format_good_reg, format_good_next;
    phase_t      phase_reg, phase_next;
    logic [1:0]  letter_cnt_reg, letter_cnt_next;
    logic [7:0]  first_letter_reg, first_letter_next;
    logic [63:0] acc_reg, acc_next;
    logic        neg_reg, neg_next;
    logic        ovf_reg, ovf_next;
    logic        unp_reg, unp_next;
    logic [31:0] held_time_reg, held_time_next;
    logic [15:0] held_lat_deg_reg, held_lat_deg_next;
    logic [15:0] held_lat_min_reg, held_lat_min_next;
    logic [31:0] held_lat_frc_reg, held_lat_frc_next;
    logic [15:0] held_lon_deg_reg, held_lon_deg_next;
    logic [15:0] held_lon_min_reg, held_lon_min_next;
    logic [31:0] held_lon_frc_reg, held_lon_frc_next;
    logic        held_south_reg, held_south_next;
    logic        held_west_reg, held_west_next;

    // result register
    logic        res_valid_reg;
    logic        res_ok_reg;
    logic [31:0] res_time_reg;
    logic [15:0] res_lat_deg_reg;
    logic [15:0] res_lat_min_reg;
    logic [31:0] res_lat_frc_reg;
    logic        res_south_reg;
    logic [15:0] res_lon_deg_reg;
    logic [15:0] res_lon_min_reg;
    logic [31:0] res_lon_frc_reg;
    logic        res_west_reg;

    logic        out_free;
    logic        parse_en;
    logic [3:0]  digit;
    logic [63:0] acc_grown;
    logic        digit_ovf;
    logic [31:0] field_val;
    logic        rec_ok;

    assign out_free   = !res_valid_reg || !result_stall;
    assign parse_en   = in_valid_reg && (!in_end_reg || out_free);
    assign byte_stall = in_valid_reg && !parse_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!byte_stall)
        begin
            in_valid_reg <= byte_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!byte_stall && byte_valid)
        begin
            in_char_reg <= char_in;
            in_end_reg  <= record_end;
        end
    end

    // digit step: acc*10 + d, checked against the limit quotient and remainder
    assign digit     = in_char_reg[3:0];
    assign acc_grown = {acc_reg[60:0], 3'b000} + {acc_reg[62:0], 1'b0} + {60'd0, digit};
    assign digit_ovf = neg_reg ? ((acc_reg > NEG_QUOT) || (acc_reg == NEG_QUOT && digit > NEG_REM))
                               : ((acc_reg > POS_QUOT) || (acc_reg == POS_QUOT && digit > POS_REM));

    // only the low 32 bits of the closed field's value are ever kept
    always_comb
    begin
        if (ovf_reg || unp_reg || phase_reg != PH_DIGITS)
        begin
            field_val = 32'd0;
        end
        else if (neg_reg)
        begin
            field_val = 32'd0 - acc_reg[31:0];
        end
        else
        begin
            field_val = acc_reg[31:0];
        end
    end

    // next parse state for one byte
    always_comb
    begin
        field_number_next = field_number_reg;
        tag_pos_next      = tag_pos_reg;
        format_good_next  = format_good_reg;
        phase_next        = phase_reg;
        letter_cnt_next   = letter_cnt_reg;
        first_letter_next = first_letter_reg;
        acc_next          = acc_reg;
        neg_next          = neg_reg;
        ovf_next          = ovf_reg;
        unp_next          = unp_reg;
        held_time_next    = held_time_reg;
        held_lat_deg_next = held_lat_deg_reg;
        held_lat_min_next = held_lat_min_reg;
        held_lat_frc_next = held_lat_frc_reg;
        held_lon_deg_next = held_lon_deg_reg;
        held_lon_min_next = held_lon_min_reg;
        held_lon_frc_next = held_lon_frc_reg;
        held_south_next   = held_south_reg;
        held_west_next    = held_west_reg;

        if (in_char_reg == CH_SEP)
        begin
            // close the current field
            if (field_number_reg == FLD_TAG)
            begin
                if (tag_pos_reg != TAG_LEN)
                begin
                    format_good_next = 1'b0;
                end
            end
            else if (is_numeric_field(field_number_reg))
            begin
                if (phase_reg == PH_BLANK)
                begin
                    format_good_next = 1'b0;
                end
                case (field_number_reg)
                    FLD_TIME:    held_time_next    = field_val;
                    FLD_LAT_DEG: held_lat_deg_next = field_val[15:0];
                    FLD_LAT_MIN: held_lat_min_next = field_val[15:0];
                    FLD_LAT_FRC: held_lat_frc_next = field_val;
                    FLD_LON_DEG: held_lon_deg_next = field_val[15:0];
                    FLD_LON_MIN: held_lon_min_next = field_val[15:0];
                    FLD_LON_FRC: held_lon_frc_next = field_val;
                    default:     ;
                endcase
            end
            else if (field_number_reg == FLD_LAT_DIR)
            begin
                if (letter_cnt_reg != 2'd1 ||
                    (first_letter_reg != CH_N && first_letter_reg != CH_S))
                begin
                    format_good_next = 1'b0;
                end
                if (first_letter_reg != CH_N)
                begin
                    held_south_next = 1'b1;
                end
            end
            else if (field_number_reg == FLD_LON_DIR)
            begin
                if (letter_cnt_reg != 2'd1 ||
                    (first_letter_reg != CH_E && first_letter_reg != CH_W))
                begin
                    format_good_next = 1'b0;
                end
                if (first_letter_reg == CH_W)
                begin
                    held_west_next = 1'b1;
                end
            end

            tag_pos_next      = 3'd0;
            phase_next        = PH_BLANK;
            letter_cnt_next   = 2'd0;
            first_letter_next = 8'd0;
            acc_next          = 64'd0;
            neg_next          = 1'b0;
            ovf_next          = 1'b0;
            unp_next          = 1'b0;
            if (field_number_reg < FIELD_LIMIT)
            begin
                field_number_next = field_number_reg + 5'd1;
            end
        end
        else if (field_number_reg == FLD_TAG)
        begin
            if (tag_pos_reg < TAG_LEN && in_char_reg == tag_char(tag_pos_reg))
            begin
                tag_pos_next = tag_pos_reg + 3'd1;
            end
            else
            begin
                format_good_next = 1'b0;
            end
        end
        else if (is_numeric_field(field_number_reg))
        begin
            if (phase_reg == PH_BLANK && is_blank(in_char_reg))
            begin
                unp_next = 1'b1;
            end
            else if (phase_reg == PH_BLANK && in_char_reg == CH_MINUS)
            begin
                neg_next   = 1'b1;
                phase_next = PH_SIGN;
            end
            else if (is_digit(in_char_reg))
            begin
                phase_next = PH_DIGITS;
                if (!ovf_reg)
                begin
                    if (digit_ovf)
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        acc_next = acc_grown;
                    end
                end
            end
            else
            begin
                format_good_next = 1'b0;
            end
        end
        else if (field_number_reg == FLD_LAT_DIR || field_number_reg == FLD_LON_DIR)
        begin
            // blanks before the letter are skipped, anything after it is counted
            if (!(letter_cnt_reg == 2'd0 && is_blank(in_char_reg)))
            begin
                if (letter_cnt_reg == 2'd0)
                begin
                    first_letter_next = in_char_reg;
                end
                if (letter_cnt_reg < 2'd2)
                begin
                    letter_cnt_next = letter_cnt_reg + 2'd1;
                end
            end
        end
    end

    // the close on the last byte only touches the last field, which holds nothing
    assign rec_ok = format_good_next && (field_number_next == LAST_FIELD);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_number_reg <= 5'd0;
            tag_pos_reg      <= 3'd0;
            format_good_reg  <= 1'b1;
            phase_reg        <= PH_BLANK;
            letter_cnt_reg   <= 2'd0;
            first_letter_reg <= 8'd0;
            acc_reg          <= 64'd0;
            neg_reg          <= 1'b0;
            ovf_reg          <= 1'b0;
            unp_reg          <= 1'b0;
            held_time_reg    <= 32'd0;
            held_lat_deg_reg <= 16'd0;
            held_lat_min_reg <= 16'd0;
            held_lat_frc_reg <= 32'd0;
            held_lon_deg_reg <= 16'd0;
            held_lon_min_reg <= 16'd0;
            held_lon_frc_reg <= 32'd0;
            held_south_reg   <= 1'b0;
            held_west_reg    <= 1'b0;
        end
        else if (parse_en)
        begin
            if (in_end_reg)
            begin
                field_number_reg <= 5'd0;
                tag_pos_reg      <= 3'd0;
                format_good_reg  <= 1'b1;
                phase_reg        <= PH_BLANK;
                letter_cnt_reg   <= 2'd0;
                first_letter_reg <= 8'd0;
                acc_reg          <= 64'd0;
                neg_reg          <= 1'b0;
                ovf_reg          <= 1'b0;
                unp_reg          <= 1'b0;
                held_time_reg    <= 32'd0;
                held_lat_deg_reg <= 16'd0;
                held_lat_min_reg <= 16'd0;
                held_lat_frc_reg <= 32'd0;
                held_lon_deg_reg <= 16'd0;
                held_lon_min_reg <= 16'd0;
                held_lon_frc_reg <= 32'd0;
                held_south_reg   <= 1'b0;
                held_west_reg    <= 1'b0;
            end
            else
            begin
                field_number_reg <= field_number_next;
                tag_pos_reg      <= tag_pos_next;
                format_good_reg  <= format_good_next;
                phase_reg        <= phase_next;
                letter_cnt_reg   <= letter_cnt_next;
                first_letter_reg <= first_letter_next;
                acc_reg          <= acc_next;
                neg_reg          <= neg_next;
                ovf_reg          <= ovf_next;
                unp_reg          <= unp_next;
                held_time_reg    <= held_time_next;
                held_lat_deg_reg <= held_lat_deg_next;
                held_lat_min_reg <= held_lat_min_next;
                held_lat_frc_reg <= held_lat_frc_next;
                held_lon_deg_reg <= held_lon_deg_next;
                held_lon_min_reg <= held_lon_min_next;
                held_lon_frc_reg <= held_lon_frc_next;
                held_south_reg   <= held_south_next;
                held_west_reg    <= held_west_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (parse_en && in_end_reg)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    // failed records report all values as zero
    always_ff @(posedge clk)
    begin
        if (parse_en && in_end_reg)
        begin
            res_ok_reg      <= rec_ok;
            res_time_reg    <= rec_ok ? held_time_next    : 32'd0;
            res_lat_deg_reg <= rec_ok ? held_lat_deg_next : 16'd0;
            res_lat_min_reg <= rec_ok ? held_lat_min_next : 16'd0;
            res_lat_frc_reg <= rec_ok ? held_lat_frc_next : 32'd0;
            res_south_reg   <= rec_ok && held_south_next;
            res_lon_deg_reg <= rec_ok ? held_lon_deg_next : 16'd0;
            res_lon_min_reg <= rec_ok ? held_lon_min_next : 16'd0;
            res_lon_frc_reg <= rec_ok ? held_lon_frc_next : 32'd0;
            res_west_reg    <= rec_ok && held_west_next;
        end
    end

    assign result_valid = res_valid_reg;
    assign record_valid = res_ok_reg;
    assign timestamp    = res_time_reg;
    assign lat_degrees  = res_lat_deg_reg;
    assign lat_minutes  = res_lat_min_reg;
    assign lat_fraction = res_lat_frc_reg;
    assign lat_south    = res_south_reg;
    assign lon_degrees  = res_lon_deg_reg;
    assign lon_minutes  = res_lon_min_reg;
    assign lon_fraction = res_lon_frc_reg;
    assign lon_west     = res_west_reg;

    `PRP_ASSERT_NOW(a_field_saturates, clk, rst_n, 1'b1, field_number_reg <= FIELD_LIMIT)
    `PRP_ASSERT_NOW(a_tag_only_in_first, clk, rst_n, tag_pos_reg != 3'd0, field_number_reg == FLD_TAG)
    `PRP_ASSERT_NOW(a_letters_only_in_dir, clk, rst_n, letter_cnt_reg != 2'd0, field_number_reg == FLD_LAT_DIR || field_number_reg == FLD_LON_DIR)
    `PRP_ASSERT_NEXT(a_end_restarts, clk, rst_n, parse_en && in_end_reg, field_number_reg == 5'd0 && format_good_reg && res_valid_reg)
    `PRP_ASSERT_NOW(a_bad_record_zero, clk, rst_n, res_valid_reg && !res_ok_reg, res_time_reg == 32'd0 && res_lat_frc_reg == 32'd0 && res_lon_frc_reg == 32'd0 && !res_south_reg && !res_west_reg)

endmodule

`default_nettype wire

>>> test/position_fix_monitor.sv
`timescale 1ns / 1ps
// position fix monitor: watches both channels of position_record_parser, works out the
// fix each record should give and checks every result beat against it
// depends on prp_pkg
module position_fix_monitor
    import prp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    input  logic        byte_stall,
    input  logic [7:0]  char_in,
    input  logic        record_end,
    input  logic        result_valid,
    input  logic        result_stall,
    input  logic        record_valid,
    input  logic [31:0] timestamp,
    input  logic [15:0] lat_degrees,
    input  logic [15:0] lat_minutes,
    input  logic [31:0] lat_fraction,
    input  logic        lat_south,
    input  logic [15:0] lon_degrees,
    input  logic [15:0] lon_minutes,
    input  logic [31:0] lon_fraction,
    input  logic        lon_west,
    output int          mismatches,
    output int          outstanding
);

    typedef struct packed {
        logic        ok;
        logic [31:0] ts;
        logic [15:0] lat_d;
        logic [15:0] lat_m;
        logic [31:0] lat_f;
        logic        south;
        logic [15:0] lon_d;
        logic [15:0] lon_m;
        logic [31:0] lon_f;
        logic        west;
    } fix_t;

    localparam logic [47:0] TAG_WORD        = "gpsrmc";
    localparam logic [4:0]  FLD_SPARE_FIRST = 5'd10;
    localparam logic [4:0]  FLD_SPARE_LAST  = 5'd13;

    logic [4:0]  fld_no;
    logic [2:0]  tag_hits;
    logic        fmt_ok;
    phase_t      num_phase;
    logic [1:0]  letters;
    logic [7:0]  dir_char;
    logic [63:0] mag;
    logic        neg_seen;
    logic        ovf_seen;
    logic        blank_seen;
    fix_t        held;
    fix_t        pending_fixes[$];

    function automatic logic blank_ch(input logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic digit_ch(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic number_field(input logic [4:0] f);
        return (f >= FLD_TIME && f <= FLD_LAT_FRC) || (f >= FLD_LON_DEG && f <= FLD_LON_FRC) ||
               (f >= FLD_SPARE_FIRST && f <= FLD_SPARE_LAST);
    endfunction

    function automatic void start_field();
        tag_hits   = '0;
        num_phase  = PH_BLANK;
        letters    = '0;
        dir_char   = '0;
        mag        = '0;
        neg_seen   = 1'b0;
        ovf_seen   = 1'b0;
        blank_seen = 1'b0;
    endfunction

    function automatic void start_record();
        fld_no = '0;
        fmt_ok = 1'b1;
        held   = '0;
        start_field();
    endfunction

    function automatic void shift_digit(input logic [7:0] c);
        logic [63:0] d;
        logic [63:0] lim;
        d = 64'(c) - 64'h30;
        lim = neg_seen ? NEG_LIMIT : POS_LIMIT;
        num_phase = PH_DIGITS;
        if (!ovf_seen)
        begin
            if (mag > (lim - d) / 64'd10)
                ovf_seen = 1'b1;
            else
                mag = mag * 64'd10 + d;
        end
    endfunction

    function automatic void end_field();
        logic [63:0] v;
        if (fld_no == FLD_TAG)
        begin
            if (tag_hits != TAG_LEN)
                fmt_ok = 1'b0;
        end
        else if (number_field(fld_no))
        begin
            if (num_phase == PH_BLANK)
                fmt_ok = 1'b0;
            // leading blank, bare sign or overflow all read as zero
            if (ovf_seen || blank_seen || num_phase != PH_DIGITS)
                v = '0;
            else
                v = neg_seen ? 64'd0 - mag : mag;
            case (fld_no)
                FLD_TIME:    held.ts    = v[31:0];
                FLD_LAT_DEG: held.lat_d = v[15:0];
                FLD_LAT_MIN: held.lat_m = v[15:0];
                FLD_LAT_FRC: held.lat_f = v[31:0];
                FLD_LON_DEG: held.lon_d = v[15:0];
                FLD_LON_MIN: held.lon_m = v[15:0];
                FLD_LON_FRC: held.lon_f = v[31:0];
                default: ;
            endcase
        end
        else if (fld_no == FLD_LAT_DIR)
        begin
            if (letters != 2'd1 || (dir_char != CH_N && dir_char != CH_S))
                fmt_ok = 1'b0;
            if (dir_char != CH_N)
                held.south = 1'b1;
        end
        else if (fld_no == FLD_LON_DIR)
        begin
            if (letters != 2'd1 || (dir_char != CH_E && dir_char != CH_W))
                fmt_ok = 1'b0;
            if (dir_char == CH_W)
                held.west = 1'b1;
        end
        start_field();
    endfunction

    function automatic void parse_char(input logic [7:0] c, input logic last);
        fix_t r;
        int   k;
        k = tag_hits;
        if (c == CH_SEP)
        begin
            end_field();
            if (fld_no < FIELD_LIMIT)
                fld_no = fld_no + 5'd1;
        end
        else if (fld_no == FLD_TAG)
        begin
            if (k < 6 && c == TAG_WORD[8 * (5 - k) +: 8])
                tag_hits = tag_hits + 3'd1;
            else
                fmt_ok = 1'b0;
        end
        else if (number_field(fld_no))
        begin
            if (num_phase == PH_BLANK && blank_ch(c))
                blank_seen = 1'b1;
            else if (num_phase == PH_BLANK && c == CH_MINUS)
            begin
                neg_seen  = 1'b1;
                num_phase = PH_SIGN;
            end
            else if (digit_ch(c))
                shift_digit(c);
            else
                fmt_ok = 1'b0;
        end
        else if (fld_no == FLD_LAT_DIR || fld_no == FLD_LON_DIR)
        begin
            // blanks before the letter are skipped, anything after it counts
            if (!(letters == 2'd0 && blank_ch(c)))
            begin
                if (letters == 2'd0)
                    dir_char = c;
                if (letters < 2'd2)
                    letters = letters + 2'd1;
            end
        end
        if (last)
        begin
            end_field();
            r = '0;
            if (fmt_ok && fld_no == LAST_FIELD)
            begin
                r    = held;
                r.ok = 1'b1;
            end
            pending_fixes.push_back(r);
            start_record();
        end
    endfunction

    task automatic compare_field(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s expected %0h got %0h", $time, what, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor_beats
        fix_t want;
        if (!rst_n)
        begin
            start_record();
            pending_fixes.delete();
            outstanding = 0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (pending_fixes.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result beat with no record pending, expected none got %0h",
                             $time, record_valid);
                end
                else
                begin
                    want = pending_fixes.pop_front();
                    compare_field("record_valid", 32'(want.ok), 32'(record_valid));
                    compare_field("timestamp", want.ts, timestamp);
                    compare_field("lat_degrees", 32'(want.lat_d), 32'(lat_degrees));
                    compare_field("lat_minutes", 32'(want.lat_m), 32'(lat_minutes));
                    compare_field("lat_fraction", want.lat_f, lat_fraction);
                    compare_field("lat_south", 32'(want.south), 32'(lat_south));
                    compare_field("lon_degrees", 32'(want.lon_d), 32'(lon_degrees));
                    compare_field("lon_minutes", 32'(want.lon_m), 32'(lon_minutes));
                    compare_field("lon_fraction", want.lon_f, lon_fraction);
                    compare_field("lon_west", 32'(want.west), 32'(lon_west));
                end
            end
            if (byte_valid && !byte_stall)
                parse_char(char_in, record_end);
            outstanding = pending_fixes.size();
        end
    end

endmodule

>>> test/tb_position_record_parser.sv
`timescale 1ns / 1ps
// top of the position_record_parser bench: builds record text, feeds it in bursts,
// stalls the result side and gives the verdict
// depends on prp_pkg, position_record_parser and position_fix_monitor
module tb_position_record_parser;
    import prp_pkg::*;

    localparam int QUIET_LIMIT = 1000;
    localparam int ITEM_TARGET = 1850;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        byte_valid = 1'b0;
    logic        byte_stall;
    logic [7:0]  char_in = 8'h00;
    logic        record_end = 1'b0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic        record_valid;
    logic [31:0] timestamp;
    logic [15:0] lat_degrees;
    logic [15:0] lat_minutes;
    logic [31:0] lat_fraction;
    logic        lat_south;
    logic [15:0] lon_degrees;
    logic [15:0] lon_minutes;
    logic [31:0] lon_fraction;
    logic        lon_west;
    int          mismatches;
    int          outstanding;

    int          burst_left = 0;
    int          stall_left = 0;
    int          stall_style = 0;
    int          quiet_cycles = 0;
    int          sent_bytes = 0;
    int          lines_sent = 0;
    logic [7:0]  line_buf[$];

    position_record_parser uut (.*);
    position_fix_monitor fix_monitor (.*);

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // receiver: runs of no stall, random stall, or long holds
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_left  = $urandom_range(1, 24);
            stall_style = $urandom_range(0, 2);
        end
        stall_left--;
        case (stall_style)
            0:       result_stall <= 1'b0;
            1:       result_stall <= ($urandom_range(0, 1) == 1);
            default: result_stall <= (stall_left > 2);
        endcase
    end

    always @(posedge clk)
    begin
        if (!rst_n || (byte_valid && !byte_stall) || (result_valid && !result_stall))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    task automatic send_beat(input logic [7:0] c, input logic last);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
            if (gap > 0)
            begin
                byte_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        byte_valid <= 1'b1;
        char_in    <= c;
        record_end <= last;
        @(posedge clk);
        while (byte_stall)
            @(posedge clk);
    endtask

    task automatic send_line();
        for (int i = 0; i < line_buf.size(); i++)
            send_beat(line_buf[i], i == line_buf.size() - 1);
        sent_bytes += line_buf.size();
        lines_sent++;
        line_buf.delete();
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++)
            line_buf.push_back(s[i]);
    endtask

    function automatic logic [7:0] spare_byte();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        return (c == CH_SEP) ? 8'hBB : c;
    endfunction

    function automatic string fix_line(input string t, la_d, la_m, la_f, ns,
                                       lo_d, lo_m, lo_f, ew);
        return {"gpsrmc;", t, ";", la_d, ";", la_m, ";", la_f, ";", ns, ";", lo_d, ";",
                lo_m, ";", lo_f, ";", ew, ";1;22;-3;4", ";;;;;", ";;;;;"};
    endfunction

    task automatic put_number(input logic allow_bad);
        int    pick;
        int    n;
        string limit_text[4];
        limit_text = '{"9223372036854775807", "9223372036854775808",
                       "-9223372036854775808", "-9223372036854775809"};
        pick = $urandom_range(0, 31);
        if (allow_bad && pick == 0)
            return;
        if (allow_bad && pick == 1)
        begin
            put_text("  ");
            return;
        end
        if (pick == 3)
        begin
            line_buf.push_back(CH_MINUS);
            return;
        end
        if (pick == 4)
        begin
            put_text(limit_text[$urandom_range(0, 3)]);
            return;
        end
        if (pick == 2)
            line_buf.push_back(8'h20);
        if ($urandom_range(0, 3) == 0)
            line_buf.push_back(CH_MINUS);
        n = ($urandom_range(0, 5) == 0) ? $urandom_range(4, 20) : $urandom_range(1, 3);
        repeat (n)
            line_buf.push_back(8'h30 + 8'($urandom_range(0, 9)));
        if (allow_bad && pick == 5)
            line_buf.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic build_fix(input logic allow_bad);
        line_buf.delete();
        put_text("gpsrmc");
        for (int f = 1; f <= 23; f++)
        begin
            line_buf.push_back(CH_SEP);
            if (f == FLD_LAT_DIR || f == FLD_LON_DIR)
            begin
                if ($urandom_range(0, 3) == 0)
                    line_buf.push_back(8'h20);
                if (f == FLD_LAT_DIR)
                    line_buf.push_back($urandom_range(0, 1) ? CH_N : CH_S);
                else
                    line_buf.push_back($urandom_range(0, 1) ? CH_E : CH_W);
                if (allow_bad && $urandom_range(0, 7) == 0)
                    line_buf.push_back(8'($urandom_range(0, 255)));
            end
            else if (f <= 13)
                put_number(allow_bad);
            else if ($urandom_range(0, 7) == 0)
                repeat ($urandom_range(1, 4))
                    line_buf.push_back(spare_byte());
        end
    endtask

    task automatic mangle_line();
        int kind;
        int pos;
        kind = $urandom_range(0, 3);
        pos  = $urandom_range(0, line_buf.size() - 1);
        case (kind)
            0: line_buf[pos] = 8'($urandom_range(0, 255));
            1: line_buf.insert(pos, CH_SEP);
            2:
            begin
                for (int i = pos; i < line_buf.size(); i++)
                    if (line_buf[i] == CH_SEP)
                    begin
                        line_buf.delete(i);
                        break;
                    end
            end
            default:
            begin
                while (line_buf.size() > pos + 1)
                    void'(line_buf.pop_back());
            end
        endcase
    endtask

    initial
    begin : stimulus
        int kind;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed records
        put_text(fix_line("0", "0", "0", "0", "N", "0", "0", "0", "E"));
        send_line();
        put_text(fix_line("9223372036854775807", "-1", "65535", "4294967295", "S",
                          "-9223372036854775808", "-32768", "-4294967296", "W"));
        send_line();
        // overflow both ways, leading blanks, bare sign, wrap to zero
        put_text(fix_line("9223372036854775808", "-9223372036854775809", " 12", "-", " N",
                          "  7", "00065536", "18446744073709551616", "\tW"));
        send_line();
        put_text(fix_line("", "1", "2", "3", "N", "4", "5", "6", "E"));
        send_line();
        put_text(fix_line("1", "  ", "2", "3", "N", "4", "5", "6", "E"));
        send_line();
        put_text(fix_line("1", "2", "3", "4", "N ", "5", "6", "7", "E"));
        send_line();
        put_text(fix_line("1", "2", "3", "4", "NS", "5", "6", "7", "EW"));
        send_line();
        put_text(fix_line("1", "2 ", "3", "\200", "X", "5", "6-", "7", "Q"));
        send_line();
        put_text(fix_line("5", "6", "7", "8", "S", "9", "10", "11", "W"));
        line_buf[5] = "d";
        send_line();
        put_text(fix_line("5", "6", "7", "8", "S", "9", "10", "11", "W"));
        line_buf.insert(6, "x");
        send_line();
        put_text(fix_line("5", "6", "7", "8", "S", "9", "10", "11", "W"));
        line_buf.delete(5);
        send_line();
        // one field too many, one too few
        put_text(fix_line("5", "6", "7", "8", "S", "9", "10", "11", "W"));
        line_buf.push_back(CH_SEP);
        send_line();
        put_text(fix_line("5", "6", "7", "8", "S", "9", "10", "11", "W"));
        void'(line_buf.pop_back());
        send_line();
        // text in the ignored tail fields, last field not empty
        put_text(fix_line("4242", "88", "59", "123456", "N", "179", "1", "999", "W"));
        line_buf.insert(line_buf.size() - 3, 8'hFF);
        line_buf.push_back("z");
        send_line();
        put_text(";");
        send_line();
        put_text("g");
        send_line();

        // random records: mostly clean, some broken, some plain noise
        while (sent_bytes < ITEM_TARGET || lines_sent < 36)
        begin
            kind = $urandom_range(0, 9);
            if (kind == 0)
            begin
                line_buf.delete();
                repeat ($urandom_range(1, 30))
                    line_buf.push_back(8'($urandom_range(0, 255)));
            end
            else
            begin
                build_fix(kind <= 3);
                if (kind <= 2)
                    mangle_line();
            end
            send_line();
        end
        byte_valid <= 1'b0;

        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
